// ===== src/joint_filtered_pd_controller_defines.svh =====
// ----------------------------------------------------------------------------
// joint_filtered_pd_controller_defines
// assertion macros shared by the controller rtl
// ----------------------------------------------------------------------------
`ifndef JOINT_FILTERED_PD_CONTROLLER_DEFINES_SVH
`define JOINT_FILTERED_PD_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define JFPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define JFPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// jfpd_pkg
// types and codes of the joint filtered pd controller
// ----------------------------------------------------------------------------
package jfpd_pkg;

    localparam logic [2:0] KIND_SET_TARGET = 3'd0;
    localparam logic [2:0] KIND_ENTER      = 3'd1;
    localparam logic [2:0] KIND_STEP       = 3'd2;
    localparam logic [2:0] KIND_LOAD_GAINS = 3'd3;
    localparam logic [2:0] KIND_RESET      = 3'd4;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NOT_ENTERED = 2'd1;
    localparam logic [1:0] STATUS_NO_TARGET   = 2'd2;
    localparam logic [1:0] STATUS_SATURATED   = 2'd3;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam int          DIV_STEPS = 27;

    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         joint;
        logic signed [31:0] measured_position;
        logic signed [31:0] measured_velocity;
        logic signed [31:0] target_position;
        logic [15:0]        step_time_us;
        logic signed [31:0] proportional_gain;
        logic signed [31:0] derivative_gain;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] command_position;
        logic signed [31:0] command_velocity;
        logic signed [31:0] command_torque;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] filt;
        logic signed [31:0] tgt;
        logic signed [31:0] kp;
        logic signed [31:0] kd;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FILT,
        S_VEL,
        S_DINIT,
        S_DIV,
        S_VSAT,
        S_T1,
        S_T2,
        S_SUM,
        S_DONE
    } t_state;

endpackage

// ===== src/joint_filtered_pd_controller.sv =====
// ----------------------------------------------------------------------------
// joint_filtered_pd_controller
// per-joint low-pass filtered pd controller, state held in one joint memory
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        input      i_in_valid / o_in_ready / i_in_data
// out       output     o_out_valid / i_out_ready / o_out_data
// cfg       input      i_cfg_we / i_cfg_data (filter alpha)
//
// one item at a time; a control step passes exec, filter, velocity, divider
// init, the 2-bit-per-cycle velocity divider, velocity saturation, two
// shared-multiplier torque terms and sum before done registers the result
// dt of zero skips from filter to the torque terms; other items go to done
// synchronous active-low reset clears flags, gains valid bits and alpha
// a stalled output holds the finished result until transfer
// ----------------------------------------------------------------------------
`include "joint_filtered_pd_controller_defines.svh"

module joint_filtered_pd_controller #(
    parameter int JOINTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jfpd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jfpd_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [16:0]         i_cfg_data
);

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    function automatic logic signed [49:0] rnd_q16(input logic signed [67:0] x);
        logic signed [67:0] v;
        v = (x + 68'sd32768) >>> 16;
        return v[49:0];
    endfunction

    jfpd_pkg::t_state r_state, n_state;

    jfpd_pkg::t_entry   r_mem [JOINTS];
    jfpd_pkg::t_entry   r_rdata;
    jfpd_pkg::t_entry   w_wdata;
    logic               w_we;

    jfpd_pkg::t_in_item r_item;
    logic [AW-1:0]      r_addr;
    logic [AW+2:0]      w_jx_in, w_jx_reg;
    logic [AW-1:0]      w_addr_in;
    logic               w_inr;

    logic [JOINTS-1:0]  r_entered, r_tvalid, r_gvalid;
    logic [16:0]        r_alpha;
    logic [16:0]        w_alpha;

    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod, r_prod;
    logic               w_mul_en;

    logic signed [31:0] r_now, r_cvel, r_ctau, r_cpos;
    logic signed [49:0] r_t1;
    logic [1:0]         r_status;
    logic               r_sat, r_neg;
    logic [15:0]        r_rem;
    logic [53:0]        r_num, r_quo;
    logic [4:0]         r_cnt;
    logic [15:0]        t_rem;
    logic [53:0]        t_num, t_quo;
    logic [16:0]        t_sh;

    logic signed [31:0] w_kp, w_kd, w_prev;
    logic               w_step_ok;
    logic               w_accept;
    logic               w_out_free;

    logic signed [67:0] w_mag;
    logic signed [33:0] w_now;
    logic signed [49:0] w_t2;
    logic signed [50:0] w_sum;

    logic               w_in_exec, w_in_sum, w_in_div, w_flags_ok, w_cnt_ok;

    assign w_jx_in   = {{AW{1'b0}}, i_in_data.joint};
    assign w_addr_in = w_jx_in[AW-1:0];
    assign w_jx_reg  = {{AW{1'b0}}, r_item.joint};
    assign w_inr     = (32'(w_jx_reg) < JOINTS);
    assign w_alpha   = (r_alpha > jfpd_pkg::ALPHA_ONE) ? jfpd_pkg::ALPHA_ONE : r_alpha;
    assign w_kp      = r_gvalid[r_addr] ? r_rdata.kp : 32'sd0;
    assign w_kd      = r_gvalid[r_addr] ? r_rdata.kd : 32'sd0;
    assign w_prev    = r_rdata.filt;
    assign w_step_ok = r_entered[r_addr] && r_tvalid[r_addr];
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_prod    = w_ma * w_mb;

    assign w_in_exec  = (r_state == jfpd_pkg::S_EXEC);
    assign w_in_sum   = (r_state == jfpd_pkg::S_SUM);
    assign w_in_div   = (r_state == jfpd_pkg::S_DIV);
    assign w_flags_ok = ((r_entered & ~r_tvalid) == '0);
    assign w_cnt_ok   = (r_cnt < 5'(jfpd_pkg::DIV_STEPS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jfpd_pkg::S_IDLE: begin
                if (i_in_valid) n_state = jfpd_pkg::S_EXEC;
            end
            jfpd_pkg::S_EXEC: begin
                if (w_inr && r_item.kind == jfpd_pkg::KIND_STEP && w_step_ok)
                    n_state = jfpd_pkg::S_FILT;
                else
                    n_state = jfpd_pkg::S_DONE;
            end
            jfpd_pkg::S_FILT: begin
                n_state = (r_item.step_time_us != 16'd0) ? jfpd_pkg::S_VEL : jfpd_pkg::S_T1;
            end
            jfpd_pkg::S_VEL:   n_state = jfpd_pkg::S_DINIT;
            jfpd_pkg::S_DINIT: n_state = jfpd_pkg::S_DIV;
            jfpd_pkg::S_DIV: begin
                if (r_cnt == 5'(jfpd_pkg::DIV_STEPS - 1)) n_state = jfpd_pkg::S_VSAT;
            end
            jfpd_pkg::S_VSAT: n_state = jfpd_pkg::S_T1;
            jfpd_pkg::S_T1:   n_state = jfpd_pkg::S_T2;
            jfpd_pkg::S_T2:   n_state = jfpd_pkg::S_SUM;
            jfpd_pkg::S_SUM:  n_state = jfpd_pkg::S_DONE;
            jfpd_pkg::S_DONE: begin
                if (w_out_free) n_state = jfpd_pkg::S_IDLE;
            end
            default: n_state = jfpd_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_we       = 1'b0;
        w_wdata    = r_rdata;
        w_mul_en   = 1'b0;
        w_ma       = '0;
        w_mb       = '0;
        case (r_state)
            jfpd_pkg::S_IDLE: o_in_ready = 1'b1;
            jfpd_pkg::S_EXEC: begin
                w_mul_en = 1'b1;
                w_ma     = {17'b0, w_alpha};
                w_mb     = 34'(r_rdata.tgt) - 34'(w_prev);
                if (w_inr) begin
                    case (r_item.kind)
                        jfpd_pkg::KIND_SET_TARGET: begin
                            w_we        = 1'b1;
                            w_wdata.tgt = r_item.target_position;
                        end
                        jfpd_pkg::KIND_ENTER: begin
                            w_we         = 1'b1;
                            w_wdata.filt = r_item.measured_position;
                            if (!r_tvalid[r_addr]) w_wdata.tgt = r_item.measured_position;
                        end
                        jfpd_pkg::KIND_LOAD_GAINS: begin
                            w_we       = 1'b1;
                            w_wdata.kp = r_item.proportional_gain;
                            w_wdata.kd = r_item.derivative_gain;
                        end
                        default: w_we = 1'b0;
                    endcase
                end
            end
            jfpd_pkg::S_VEL: begin
                w_mul_en = 1'b1;
                w_ma     = 34'sd1000000;
                w_mb     = 34'(r_now) - 34'(w_prev);
            end
            jfpd_pkg::S_T1: begin
                w_mul_en = 1'b1;
                w_ma     = 34'(w_kp);
                w_mb     = 34'(r_now) - 34'(r_item.measured_position);
            end
            jfpd_pkg::S_T2: begin
                w_mul_en = 1'b1;
                w_ma     = 34'(w_kd);
                w_mb     = 34'(r_cvel) - 34'(r_item.measured_velocity);
            end
            jfpd_pkg::S_SUM: begin
                w_we         = 1'b1;
                w_wdata.filt = r_now;
            end
            default: w_we = 1'b0;
        endcase
    end

    // divider, two quotient bits per cycle
    always_comb begin
        t_rem = r_rem;
        t_num = r_num;
        t_quo = r_quo;
        t_sh  = '0;
        for (int k = 0; k < 2; k++) begin
            t_sh  = {t_rem, t_num[53]};
            t_num = {t_num[52:0], 1'b0};
            if (t_sh >= {1'b0, r_item.step_time_us}) begin
                t_rem = 16'(t_sh - {1'b0, r_item.step_time_us});
                t_quo = {t_quo[52:0], 1'b1};
            end else begin
                t_rem = t_sh[15:0];
                t_quo = {t_quo[52:0], 1'b0};
            end
        end
    end

    assign w_mag = r_prod[67] ? -r_prod : r_prod;
    assign w_t2  = rnd_q16(r_prod);
    assign w_now = 34'(w_prev) + w_t2[33:0];
    assign w_sum = 51'(r_t1) + 51'(w_t2);

    // joint memory
    always_ff @(posedge i_clk) begin
        if (w_accept) r_rdata <= r_mem[w_addr_in];
        if (w_we) r_mem[r_addr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jfpd_pkg::S_IDLE;
            r_entered   <= '0;
            r_tvalid    <= '0;
            r_gvalid    <= '0;
            r_alpha     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_alpha <= i_cfg_data;
            if (r_state == jfpd_pkg::S_DONE && w_out_free) o_out_valid <= 1'b1;
            else if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (r_state == jfpd_pkg::S_EXEC && w_inr) begin
                case (r_item.kind)
                    jfpd_pkg::KIND_SET_TARGET: r_tvalid[r_addr] <= 1'b1;
                    jfpd_pkg::KIND_ENTER: begin
                        r_tvalid[r_addr]  <= 1'b1;
                        r_entered[r_addr] <= 1'b1;
                    end
                    jfpd_pkg::KIND_LOAD_GAINS: begin
                        r_gvalid[r_addr]  <= 1'b1;
                        r_tvalid[r_addr]  <= 1'b0;
                        r_entered[r_addr] <= 1'b0;
                    end
                    jfpd_pkg::KIND_RESET: r_entered <= '0;
                    default: r_entered <= r_entered;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
            r_addr <= w_addr_in;
        end
        if (w_mul_en) r_prod <= w_prod;
        case (r_state)
            jfpd_pkg::S_EXEC: begin
                r_sat  <= 1'b0;
                r_cvel <= '0;
                r_ctau <= '0;
                if (w_inr && r_item.kind == jfpd_pkg::KIND_ENTER)
                    r_cpos <= r_item.measured_position;
                else
                    r_cpos <= '0;
                if (!w_inr)
                    r_status <= jfpd_pkg::STATUS_NOT_ENTERED;
                else if (r_item.kind == jfpd_pkg::KIND_STEP && !r_entered[r_addr])
                    r_status <= jfpd_pkg::STATUS_NOT_ENTERED;
                else if (r_item.kind == jfpd_pkg::KIND_STEP && !r_tvalid[r_addr])
                    r_status <= jfpd_pkg::STATUS_NO_TARGET;
                else
                    r_status <= jfpd_pkg::STATUS_OK;
            end
            jfpd_pkg::S_FILT: begin
                r_now <= (r_item.step_time_us != 16'd0) ? w_now[31:0] : w_prev;
            end
            jfpd_pkg::S_DINIT: begin
                r_neg <= r_prod[67];
                r_num <= w_mag[53:0] + {39'b0, r_item.step_time_us[15:1]};
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            jfpd_pkg::S_DIV: begin
                r_rem <= t_rem;
                r_num <= t_num;
                r_quo <= t_quo;
                r_cnt <= r_cnt + 5'd1;
            end
            jfpd_pkg::S_VSAT: begin
                if (r_neg) begin
                    if (r_quo > 54'h80000000) begin
                        r_cvel <= 32'sh80000000;
                        r_sat  <= 1'b1;
                    end else begin
                        r_cvel <= 32'(-{1'b0, r_quo[31:0]});
                    end
                end else begin
                    if (r_quo > 54'h7fffffff) begin
                        r_cvel <= 32'sh7fffffff;
                        r_sat  <= 1'b1;
                    end else begin
                        r_cvel <= r_quo[31:0];
                    end
                end
            end
            jfpd_pkg::S_T2: r_t1 <= rnd_q16(r_prod);
            jfpd_pkg::S_SUM: begin
                r_cpos <= r_now;
                if (w_sum > 51'sh7fffffff) begin
                    r_ctau   <= 32'sh7fffffff;
                    r_status <= jfpd_pkg::STATUS_SATURATED;
                end else if (w_sum < -51'sh80000000) begin
                    r_ctau   <= 32'sh80000000;
                    r_status <= jfpd_pkg::STATUS_SATURATED;
                end else begin
                    r_ctau   <= w_sum[31:0];
                    r_status <= r_sat ? jfpd_pkg::STATUS_SATURATED : jfpd_pkg::STATUS_OK;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
        if (r_state == jfpd_pkg::S_DONE && w_out_free) begin
            o_out_data.status           <= r_status;
            o_out_data.command_position <= r_cpos;
            o_out_data.command_velocity <= r_cvel;
            o_out_data.command_torque   <= r_ctau;
        end
    end

    `JFPD_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, w_accept, w_in_exec, "no exec after transfer")
    `JFPD_ASSERT_SAME(a_we_states, i_clk, i_rst_n, w_we, w_in_exec || w_in_sum, "stray write")
    `JFPD_ASSERT_SAME(a_entered_tgt, i_clk, i_rst_n, 1'b1, w_flags_ok, "entry without target")
    `JFPD_ASSERT_SAME(a_div_count, i_clk, i_rst_n, w_in_div, w_cnt_ok, "divider count overran")

endmodule

// ===== verif/joint_filtered_pd_controller_tb.sv =====
// ----------------------------------------------------------------------------
// joint_filtered_pd_controller_tb
// random and directed transfers into the joint controller; a scoreboard
// predicts every result from its own joint state and checks it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joint_filtered_pd_controller_tb;

    localparam int NJ = 8;
    localparam int WATCH_LIMIT = 20000;

    class pd_scoreboard;
        logic [16:0]         alpha;
        logic signed [31:0]  filt [NJ];
        logic signed [31:0]  tgt [NJ];
        logic signed [31:0]  kp [NJ];
        logic signed [31:0]  kd [NJ];
        bit                  entered [NJ];
        bit                  tvalid [NJ];
        jfpd_pkg::t_out_item pending [$];
        int                  errors;
        int                  checked;
        int                  steps;
        int                  sats;

        function void clear();
            alpha = '0;
            for (int i = 0; i < NJ; i++) begin
                filt[i] = '0;
                tgt[i] = '0;
                kp[i] = '0;
                kd[i] = '0;
                entered[i] = 0;
                tvalid[i] = 0;
            end
        endfunction

        function longint rnd16(longint x);
            longint v;
            v = x + 32768;
            return v >>> 16;
        endfunction

        function longint clamp32(longint x, ref bit flag);
            if (x > 64'sd2147483647) begin
                flag = 1;
                return 64'sd2147483647;
            end
            if (x < -64'sd2147483648) begin
                flag = 1;
                return -64'sd2147483648;
            end
            return x;
        endfunction

        function void note_input(jfpd_pkg::t_in_item it);
            jfpd_pkg::t_out_item r;
            int j;
            longint prev, now, a, delta, mag, qq, v, t1, t2, dt;
            bit sat;
            r = '0;
            j = it.joint;
            case (it.kind)
                jfpd_pkg::KIND_SET_TARGET: begin
                    tgt[j] = it.target_position;
                    tvalid[j] = 1;
                end
                jfpd_pkg::KIND_ENTER: begin
                    filt[j] = it.measured_position;
                    if (!tvalid[j]) begin
                        tgt[j] = it.measured_position;
                        tvalid[j] = 1;
                    end
                    entered[j] = 1;
                    r.command_position = it.measured_position;
                end
                jfpd_pkg::KIND_STEP: begin
                    if (!entered[j]) r.status = jfpd_pkg::STATUS_NOT_ENTERED;
                    else if (!tvalid[j]) r.status = jfpd_pkg::STATUS_NO_TARGET;
                    else begin
                        steps++;
                        sat = 0;
                        prev = filt[j];
                        a = (alpha > jfpd_pkg::ALPHA_ONE) ? 65536 : longint'(alpha);
                        now = prev;
                        dt = it.step_time_us;
                        if (dt != 0) begin
                            now = prev + rnd16(a * (longint'(tgt[j]) - prev));
                            delta = (now - prev) * 1000000;
                            mag = (delta < 0) ? -delta : delta;
                            qq = (mag + dt / 2) / dt;
                            v = (delta < 0) ? -qq : qq;
                            r.command_velocity = 32'(clamp32(v, sat));
                        end
                        filt[j] = 32'(now);
                        r.command_position = 32'(now);
                        t1 = rnd16(longint'(kp[j]) * (now - longint'(it.measured_position)));
                        t2 = rnd16(longint'(kd[j]) * (longint'(r.command_velocity)
                             - longint'(it.measured_velocity)));
                        r.command_torque = 32'(clamp32(t1 + t2, sat));
                        r.status = sat ? jfpd_pkg::STATUS_SATURATED : jfpd_pkg::STATUS_OK;
                        if (sat) sats++;
                    end
                end
                jfpd_pkg::KIND_LOAD_GAINS: begin
                    kp[j] = it.proportional_gain;
                    kd[j] = it.derivative_gain;
                    entered[j] = 0;
                    tvalid[j] = 0;
                end
                jfpd_pkg::KIND_RESET: begin
                    for (int i = 0; i < NJ; i++) entered[i] = 0;
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(jfpd_pkg::t_out_item got);
            jfpd_pkg::t_out_item e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $realtime, got);
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                errors++;
                $display("%0t: status exp %0d got %0d", $realtime, e.status, got.status);
            end
            if (got.command_position !== e.command_position) begin
                errors++;
                $display("%0t: position exp %h got %h", $realtime,
                         e.command_position, got.command_position);
            end
            if (got.command_velocity !== e.command_velocity) begin
                errors++;
                $display("%0t: velocity exp %h got %h", $realtime,
                         e.command_velocity, got.command_velocity);
            end
            if (got.command_torque !== e.command_torque) begin
                errors++;
                $display("%0t: torque exp %h got %h", $realtime,
                         e.command_torque, got.command_torque);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    jfpd_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_ready;
    jfpd_pkg::t_out_item out_data;
    logic                cfg_we;
    logic [16:0]         cfg_data;

    pd_scoreboard sb;
    bit  hold_off;
    int  idle_cycles;

    joint_filtered_pd_controller #(.JOINTS(NJ)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial begin
        sb = new();
        sb.clear();
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.note_input(in_data);
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", idle_cycles);
            $display("joint_filtered_pd_controller_tb: errors");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int w;
        bit held;
        held = 0;
        out_ready = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off && !held) begin
                held = 1;
                out_ready <= 0;
                repeat (300) @(posedge clk);
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (w > 0) begin
                out_ready <= 0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    function automatic logic signed [31:0] rval();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(0, 131072) - 65536);
            3: return 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(jfpd_pkg::t_in_item it, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 6) : 0;
        if (w > 0) begin
            in_valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_kind(logic [2:0] k, logic [2:0] j, logic signed [31:0] q,
                             logic signed [31:0] qd, logic signed [31:0] t,
                             logic [15:0] dt, logic signed [31:0] p,
                             logic signed [31:0] d);
        jfpd_pkg::t_in_item it;
        it.kind = k;
        it.joint = j;
        it.measured_position = q;
        it.measured_velocity = qd;
        it.target_position = t;
        it.step_time_us = dt;
        it.proportional_gain = p;
        it.derivative_gain = d;
        send(it, 1);
    endtask

    task automatic drain_and_set(logic [16:0] a);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= a;
        @(posedge clk);
        cfg_we <= 0;
        sb.alpha = a;
    endtask

    task automatic random_item(int well);
        jfpd_pkg::t_in_item it;
        logic [2:0] j;
        j = 3'($urandom_range(0, 7));
        it = '0;
        it.joint = j;
        it.measured_position = rval();
        it.measured_velocity = rval();
        it.target_position = rval();
        it.proportional_gain = rval();
        it.derivative_gain = rval();
        case ($urandom_range(0, 3))
            0: it.step_time_us = 0;
            1: it.step_time_us = 16'hffff;
            2: it.step_time_us = 16'($urandom_range(1, 2000));
            default: it.step_time_us = 16'($urandom);
        endcase
        if (well) begin
            case ($urandom_range(0, 9))
                0: it.kind = jfpd_pkg::KIND_SET_TARGET;
                1: it.kind = jfpd_pkg::KIND_ENTER;
                2: it.kind = jfpd_pkg::KIND_LOAD_GAINS;
                default: it.kind = jfpd_pkg::KIND_STEP;
            endcase
            if (it.kind == jfpd_pkg::KIND_STEP && !sb.entered[j] && $urandom_range(0, 3) != 0)
                it.kind = jfpd_pkg::KIND_ENTER;
        end else begin
            it.kind = 3'($urandom_range(0, 7));
        end
        send(it, $urandom_range(0, 4) != 0);
    endtask

    initial begin
        logic [16:0] alphas [6];
        int timer;
        alphas = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd1, 17'd65535};
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: step before enter, no target, extremes, dt zero, ignored kinds
        send_kind(jfpd_pkg::KIND_STEP, 0, 0, 0, 0, 100, 0, 0);
        send_kind(jfpd_pkg::KIND_LOAD_GAINS, 1, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000);
        send_kind(jfpd_pkg::KIND_ENTER, 1, 32'sh7fffffff, 0, 0, 0, 0, 0);
        send_kind(jfpd_pkg::KIND_STEP, 1, 32'sh80000000, 32'sh7fffffff, 0, 1, 0, 0);
        drain_and_set(17'd65536);
        send_kind(jfpd_pkg::KIND_LOAD_GAINS, 2, 0, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff);
        send_kind(jfpd_pkg::KIND_ENTER, 2, 32'sh80000000, 0, 0, 0, 0, 0);
        send_kind(jfpd_pkg::KIND_SET_TARGET, 2, 0, 0, 32'sh7fffffff, 0, 0, 0);
        send_kind(jfpd_pkg::KIND_STEP, 2, 0, 32'sh80000000, 0, 1, 0, 0);
        send_kind(jfpd_pkg::KIND_STEP, 2, 0, 0, 0, 0, 0, 0);
        send_kind(jfpd_pkg::KIND_STEP, 2, 0, 0, 0, 16'hffff, 0, 0);
        send_kind(jfpd_pkg::KIND_LOAD_GAINS, 3, 0, 0, 0, 0, 32'sh10000, 32'sh8000);
        send_kind(jfpd_pkg::KIND_STEP, 3, 0, 0, 0, 10, 0, 0);
        send_kind(jfpd_pkg::KIND_SET_TARGET, 3, 0, 0, 32'sh30000, 0, 0, 0);
        send_kind(jfpd_pkg::KIND_STEP, 3, 0, 0, 0, 10, 0, 0);
        send_kind(jfpd_pkg::KIND_ENTER, 3, 32'sh10000, 0, 0, 0, 0, 0);
        send_kind(jfpd_pkg::KIND_STEP, 3, 32'sh8000, 32'sh1000, 0, 1000, 0, 0);
        send_kind(jfpd_pkg::KIND_RESET, 0, 0, 0, 0, 0, 0, 0);
        send_kind(jfpd_pkg::KIND_STEP, 3, 0, 0, 0, 10, 0, 0);
        send_kind(3'd5, 4, 0, 0, 0, 0, 0, 0);
        send_kind(3'd7, 7, 32'shffffffff, 32'shffffffff, 32'shffffffff, 16'hffff,
                  32'shffffffff, 32'shffffffff);

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_set(alphas[ph]);
            if (ph == 2) hold_off = 1;
            for (int n = 0; n < 150; n++) random_item($urandom_range(0, 4) != 0);
        end
        in_valid <= 0;

        timer = 0;
        while (sb.pending.size() != 0 && timer < 40000) begin
            @(posedge clk);
            timer++;
        end
        repeat (60) @(posedge clk);
        $display("covered %0d results, %0d active control steps, %0d saturated",
                 sb.checked, sb.steps, sb.sats);
        $display("six alpha settings from zero through above one");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("joint_filtered_pd_controller_tb: clean");
        else
            $display("joint_filtered_pd_controller_tb: errors");
        $finish;
    end
endmodule
